### design/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed");
// check that a condition never holds
`define CHK_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`endif

### design/sha256_pkg.sv
// shared types, constants and round functions of the sha-256 hasher
`timescale 1ns / 1ps
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // queue entry from front to back: a full block and whether it ends a message
  typedef struct packed {
    logic [511:0] block;
    logic         last;
  } sha_job_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/sha256_front.sv
// byte gatherer and padder: builds 64-byte blocks and hands them to the queue
`timescale 1ns / 1ps
module sha256_front
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sha_in_t  in_data,
  output logic     job_valid,
  input  logic     job_stall,
  output sha_job_t job
);

  typedef enum logic [1:0] {ST_BYTES, ST_PAD, ST_PUSH} st_t;

  st_t          st_r;
  logic [511:0] blk_r;         // byte shift register, first byte ends up on top
  logic [5:0]   fill_r;
  logic [60:0]  len_r;
  logic [63:0]  bits_r;        // bit length, shifted out a byte at a time
  logic         last_r;        // pushed block ends the message
  logic         pad_more_r;    // padding continues after this push
  logic         pad_byte_r;    // next pad byte is 0x80
  logic         len_started_r; // bytes 56..63 of this block carry the length
  logic [7:0]   wr_byte;
  logic         wr_en;

  assign job.block = blk_r;
  assign job.last  = last_r;
  assign job_valid = (st_r == ST_PUSH);
  assign in_stall  = (st_r != ST_BYTES);

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = 8'h00;
    if (st_r == ST_BYTES) begin
      wr_en   = in_valid && in_data.byte_present;
      wr_byte = in_data.data_byte;
    end else if (st_r == ST_PAD) begin
      wr_en = 1'b1;
      if (pad_byte_r) wr_byte = PAD_BYTE;
      else if (len_started_r) wr_byte = bits_r[63:56];
      else wr_byte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) blk_r <= {blk_r[503:0], wr_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_BYTES;
      fill_r <= '0;
      len_r <= '0;
      last_r <= 1'b0;
      pad_more_r <= 1'b0;
      pad_byte_r <= 1'b0;
      len_started_r <= 1'b0;
      bits_r <= '0;
    end else begin
      unique case (st_r)
        ST_BYTES: begin
          if (in_valid) begin
            if (in_data.byte_present) begin
              fill_r <= fill_r + 6'd1;
              len_r  <= len_r + 61'd1;
            end
            if (in_data.end_of_message) begin
              bits_r <= {len_r + 61'(in_data.byte_present), 3'b000};
              pad_more_r <= 1'b1;
              pad_byte_r <= 1'b1;
              last_r <= 1'b0;
              if (in_data.byte_present && fill_r == 6'd63) st_r <= ST_PUSH;
              else st_r <= ST_PAD;
            end else if (in_data.byte_present && fill_r == 6'd63) begin
              last_r <= 1'b0;
              pad_more_r <= 1'b0;
              st_r <= ST_PUSH;
            end
          end
        end
        ST_PAD: begin
          pad_byte_r <= 1'b0;
          fill_r <= fill_r + 6'd1;
          if (len_started_r) bits_r <= {bits_r[55:0], 8'h00};
          // zeros stop at byte 56, the length field follows
          if (fill_r == LEN_POS - 6'd1) len_started_r <= 1'b1;
          if (fill_r == 6'd63) begin
            last_r <= len_started_r;
            pad_more_r <= !len_started_r;
            len_started_r <= 1'b0;
            st_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!job_stall) begin
            if (pad_more_r) st_r <= ST_PAD;
            else begin
              st_r <= ST_BYTES;
              if (last_r) len_r <= '0;
            end
            last_r <= 1'b0;
          end
        end
        default: st_r <= ST_BYTES;
      endcase
    end
  end

endmodule

### design/sha256_queue.sv
// two-entry queue of blocks between front and back
`timescale 1ns / 1ps
module sha256_queue
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_stall,
  input  sha_job_t wr_job,
  output logic     rd_valid,
  input  logic     rd_stall,
  output sha_job_t rd_job
);
  `include "assert_macros.svh"

  sha_job_t mem_r [QUEUE_DEPTH];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign wr_stall = (cnt_r == 2'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `CHK_NEVER(a_cnt_range, clk, rst_n, cnt_r > 2'(QUEUE_DEPTH))
  `CHK_IMPL(a_ptr_match, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r)
  `CHK_IMPL(a_one_ptr, clk, rst_n, cnt_r == 2'd1, wp_r != rp_r)
endmodule

### design/sha256_back.sv
// compression engine: one round per cycle, then digest words out after the last block of a message
`timescale 1ns / 1ps
module sha256_back
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  output logic     job_stall,
  input  sha_job_t job,
  output logic     out_valid,
  input  logic     out_stall,
  output sha_out_t out_data
);
  `include "assert_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FOLD, ST_EMIT} st_t;

  st_t          st_r;
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];
  logic [5:0]   rnd_r;
  logic [2:0]   idx_r;
  logic         last_r;
  logic [31:0]  t1, t2, s0, s1, wn;

  assign job_stall = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_EMIT);
  assign out_data.digest_word = h_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == 3'd7);

  always_comb begin
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_r) + w_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rnd_r <= '0; idx_r <= '0; last_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[255 - 32*i -: 32];
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 16; i++) w_r[i] <= job.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            last_r <= job.last;
            rnd_r <= '0;
            st_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) st_r <= ST_FOLD;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          idx_r <= '0;
          st_r <= last_r ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[255 - 32*i -: 32];
              st_r <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_emit_last, clk, rst_n, st_r == ST_EMIT, last_r)
  `CHK_IMPL(a_round_end, clk, rst_n, st_r == ST_ROUND && rnd_r == 6'd63, ##1 st_r == ST_FOLD)
  `CHK_IMPL(a_hold, clk, rst_n, out_valid && out_stall, ##1 out_valid && $stable(idx_r))
endmodule

### design/sha256_stream_hasher_core.sv
// top level of the streaming sha-256 hasher
`timescale 1ns / 1ps
// usage
// in channel: one transfer per message byte (byte_present) and/or end marker
//   (end_of_message); an end transfer with no byte is allowed (empty message)
// out channel: eight transfers of the digest, word 0 (most significant) first,
//   last_word high on word 7
// throughput: one byte per cycle while a block gathers, with in stalled while each full block is
//   handed to a two-entry queue; the compression engine loads each block, runs its rounds and
//   folds it into the chaining words, so bytes of the next block overlap it
// padding keeps in stalled from the end transfer until the last padded block is pushed, and
//   longer while the queue is full
// with an idle engine digest word 0 is offered once the last padded block has been pushed,
//   loaded, run through its rounds and folded, and later when padding needs a second block;
//   each block still waiting ahead of it adds its own compression
// a stalled out channel holds the current word; the engine and then the queue
//   fill up and the in channel stalls in turn
// reset: synchronous active low; chaining words return to the initial value,
//   byte count and length clear, queue empties
module sha256_stream_hasher_core
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sha_out_t out_data
);

  // front to queue
  logic     f_valid, f_stall;
  sha_job_t f_job;
  // queue to back
  logic     q_valid, q_stall;
  sha_job_t q_job;

  sha256_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  sha256_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job)
  );

  sha256_back u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .out_valid, .out_stall, .out_data
  );

endmodule
